FILE: hw/rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg: shared constants and types for the text console
// Screen geometry, field widths, mode and control codes, cursor update struct.
// ----------------------------------------------------------------------------
package tccs_pkg;

  // screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_WIDTH  = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  // internal widths
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int PH_W   = $clog2(TAB_WIDTH);
  localparam int CELL_W = $clog2(CELL_COUNT);
  localparam int NXT_W  = $clog2(COLUMNS + TAB_WIDTH);

  // port field widths
  localparam int MODE_W      = 2;
  localparam int CODE_W      = 8;
  localparam int INDEX_W     = 11;
  localparam int POS_W       = 11;
  localparam int ROW_OUT_W   = 5;
  localparam int COL_OUT_W   = 7;
  localparam int CELL_DATA_W = 16;
  localparam int COLOUR_W    = 4;
  localparam int CFG_INDEX_W = 1;

  // request modes
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BACK_COLOUR = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FORE_COLOUR = 1'b1;

  localparam logic [COLOUR_W-1:0] BACK_RESET = 4'h0;
  localparam logic [COLOUR_W-1:0] FORE_RESET = 4'hF;

  // character codes
  localparam logic [CODE_W-1:0] CHAR_BS       = 8'h08;
  localparam logic [CODE_W-1:0] CHAR_TAB      = 8'h09;
  localparam logic [CODE_W-1:0] CHAR_LF       = 8'h0A;
  localparam logic [CODE_W-1:0] CHAR_CR       = 8'h0D;
  localparam logic [CODE_W-1:0] CHAR_PRINT_LO = 8'h20;
  localparam logic [CODE_W-1:0] CHAR_PRINT_HI = 8'h7F;

  localparam logic [CELL_DATA_W-1:0] BLANK_CELL = 16'h0F20;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [PH_W-1:0]  phase;
    logic             store;
    logic             scroll;
  } cursor_upd_t;

endpackage

FILE: hw/rtl/tccs_ram.sv
// ----------------------------------------------------------------------------
// tccs_ram: simple dual-port screen memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module tccs_ram #(
  parameter int DEPTH = 2000,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/tccs_cursor.sv
// ----------------------------------------------------------------------------
// tccs_cursor: cursor update for one put request
// Decodes the character and gives the next cursor, store and scroll flags.
// ----------------------------------------------------------------------------
module tccs_cursor
  import tccs_pkg::*;
(
  input  logic [CODE_W-1:0] code,
  input  logic [COL_W-1:0]  column,
  input  logic [ROW_W-1:0]  row,
  input  logic [PH_W-1:0]   phase,
  output cursor_upd_t       upd
);

  logic [NXT_W-1:0] col_ext;
  logic [NXT_W-1:0] nxt;
  logic [ROW_W:0]   row_inc;
  logic             adv;
  logic             new_row;

  always_comb begin
    col_ext    = NXT_W'(column);
    nxt        = col_ext + 1'b1;
    row_inc    = {1'b0, row} + 1'b1;
    adv        = 1'b0;
    new_row    = 1'b0;
    upd.column = column;
    upd.row    = row;
    upd.phase  = phase;
    upd.store  = 1'b0;
    upd.scroll = 1'b0;

    case (code)
      CHAR_BS: begin
        if (column != '0) begin
          upd.column = column - 1'b1;
          upd.phase  = (phase == '0) ? PH_W'(TAB_WIDTH - 1) : phase - 1'b1;
        end
      end
      CHAR_TAB: begin
        // phase tracks column modulo the tab width
        nxt       = col_ext + NXT_W'(TAB_WIDTH) - NXT_W'(phase);
        adv       = 1'b1;
        upd.phase = '0;
      end
      CHAR_CR: begin
        upd.column = '0;
        upd.phase  = '0;
      end
      CHAR_LF: begin
        upd.column = '0;
        upd.phase  = '0;
        new_row    = 1'b1;
      end
      default: begin
        if (code inside {[CHAR_PRINT_LO:CHAR_PRINT_HI]}) begin
          upd.store = 1'b1;
          adv       = 1'b1;
          upd.phase = (phase == PH_W'(TAB_WIDTH - 1)) ? '0 : phase + 1'b1;
        end
      end
    endcase

    if (adv) begin
      if (nxt >= NXT_W'(COLUMNS)) begin
        upd.column = '0;
        upd.phase  = '0;
        new_row    = 1'b1;
      end else begin
        upd.column = COL_W'(nxt);
      end
    end

    if (new_row) begin
      // past the last row: stay there and scroll
      if (row_inc == (ROW_W+1)'(ROWS)) begin
        upd.row    = ROW_W'(ROWS - 1);
        upd.scroll = 1'b1;
      end else begin
        upd.row = ROW_W'(row_inc);
      end
    end
  end

endmodule

FILE: hw/rtl/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll: 80x25 character-cell text console
// Put, clear and read requests on a screen memory under a small sequencer.
// ----------------------------------------------------------------------------
// Sequencing: a put passes through S_PUT and S_RESULT, a read through S_READ
// and S_RESULT, a no-op straight to S_RESULT, which holds while the output
// register is stalled. A scroll adds a row copy through the one read and one
// write port (S_SCROLL, S_DRAIN), then a bottom row fill (S_FILL); a clear
// blanks every cell in S_FILL. No new request is taken until back in S_IDLE.
// Reset: cursor homes, colours go to white on black, and a blanking sweep
// of all COLUMNS*ROWS cells (2000) runs before the first request is taken.
module text_console_cursor_scroll
  import tccs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [MODE_W-1:0]      mode,
  input  logic [CODE_W-1:0]      char_code,
  input  logic [INDEX_W-1:0]     cell_index,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [POS_W-1:0]       cursor_position,
  output logic [ROW_OUT_W-1:0]   cursor_row,
  output logic [COL_OUT_W-1:0]   cursor_column,
  output logic [CELL_DATA_W-1:0] cell_value,
  output logic                   scrolled,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COLOUR_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_PUT,
    S_SCROLL,
    S_DRAIN,
    S_FILL,
    S_READ,
    S_RESULT
  } state_t;

  localparam logic [CELL_W-1:0] LAST_CELL      = CELL_W'(CELL_COUNT - 1);
  localparam logic [CELL_W-1:0] LAST_ROW_START = CELL_W'((ROWS - 1) * COLUMNS);

  state_t                  state;
  logic [CELL_W-1:0]       addr;
  logic                    copy_valid;
  logic [CELL_W-1:0]       copy_dst;
  logic [COL_W-1:0]        column;
  logic [ROW_W-1:0]        row;
  logic [PH_W-1:0]         phase;
  logic [CODE_W-1:0]       req_code;
  logic                    read_ok;
  logic                    scroll_flag;
  logic [CELL_DATA_W-1:0]  read_data;
  logic [COLOUR_W-1:0]     back_colour;
  logic [COLOUR_W-1:0]     fore_colour;

  logic                    index_ok;
  logic [CELL_W-1:0]       cur_pos;
  cursor_upd_t             upd;

  logic                    ram_we;
  logic [CELL_W-1:0]       ram_waddr;
  logic [CELL_DATA_W-1:0]  ram_wdata;
  logic [CELL_W-1:0]       ram_raddr;
  logic [CELL_DATA_W-1:0]  ram_rdata;

  tccs_cursor u_cursor (
    .code   (req_code),
    .column (column),
    .row    (row),
    .phase  (phase),
    .upd    (upd)
  );

  tccs_ram #(
    .DEPTH (CELL_COUNT),
    .WIDTH (CELL_DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall = (state != S_IDLE);
  assign index_ok = (CELL_W'(cell_index) < CELL_W'(CELL_COUNT)) &&
                    (INDEX_W'(cell_index) < INDEX_W'(CELL_COUNT));
  assign cur_pos  = CELL_W'(row) * CELL_W'(COLUMNS) + CELL_W'(column);

  // write port: pending copy first, then put, then blanking sweeps
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = BLANK_CELL;
    if (copy_valid) begin
      ram_we    = 1'b1;
      ram_waddr = copy_dst;
      ram_wdata = ram_rdata;
    end else if (state == S_PUT) begin
      ram_we    = upd.store;
      ram_waddr = cur_pos;
      ram_wdata = {back_colour, fore_colour, req_code};
    end else if (state == S_INIT || state == S_FILL) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = (state == S_SCROLL) ? addr :
                     (index_ok ? CELL_W'(cell_index) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      addr        <= '0;
      copy_valid  <= 1'b0;
      column      <= '0;
      row         <= '0;
      phase       <= '0;
      out_valid   <= 1'b0;
      back_colour <= BACK_RESET;
      fore_colour <= FORE_RESET;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BACK_COLOUR: back_colour <= cfg_data;
          REG_FORE_COLOUR: fore_colour <= cfg_data;
          default: ;
        endcase
      end

      copy_valid <= (state == S_SCROLL);
      copy_dst   <= addr - CELL_W'(COLUMNS);

      // a result leaving while the next one waits is replaced in S_RESULT
      if (out_valid && !out_stall && state != S_RESULT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_INIT: begin
          if (addr == LAST_CELL) begin
            addr  <= '0;
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_code    <= char_code;
            read_ok     <= index_ok;
            read_data   <= '0;
            scroll_flag <= 1'b0;
            case (mode)
              MODE_PUT:   state <= S_PUT;
              MODE_CLEAR: begin
                column <= '0;
                row    <= '0;
                phase  <= '0;
                addr   <= '0;
                state  <= S_FILL;
              end
              MODE_READ:  state <= S_READ;
              default:    state <= S_RESULT;
            endcase
          end
        end
        S_PUT: begin
          column      <= upd.column;
          row         <= upd.row;
          phase       <= upd.phase;
          scroll_flag <= upd.scroll;
          if (upd.scroll) begin
            addr  <= CELL_W'(COLUMNS);
            state <= S_SCROLL;
          end else begin
            state <= S_RESULT;
          end
        end
        S_SCROLL: begin
          if (addr == LAST_CELL) begin
            state <= S_DRAIN;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_DRAIN: begin
          // last copy write lands this cycle
          addr  <= LAST_ROW_START;
          state <= S_FILL;
        end
        S_FILL: begin
          if (addr == LAST_CELL) begin
            state <= S_RESULT;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_READ: begin
          read_data <= read_ok ? ram_rdata : '0;
          state     <= S_RESULT;
        end
        S_RESULT: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_valid       <= 1'b1;
            cursor_position <= POS_W'(cur_pos);
            cursor_row      <= ROW_OUT_W'(row);
            cursor_column   <= COL_OUT_W'(column);
            cell_value      <= read_data;
            scrolled        <= scroll_flag;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row < ROW_W'(ROWS))
    else $error("cursor row past last row");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    column < COL_W'(COLUMNS))
    else $error("cursor column past last column");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    out_valid && scrolled |-> cursor_row == ROW_OUT_W'(ROWS - 1))
    else $error("scrolled result not on last row");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !ram_we)
    else $error("screen write while idle");
`endif

endmodule
